// ===== rtl/core/gpa_pkg.sv =====
// gpa_pkg: shared constants, codes and types of the guarded page allocator
// no dependencies; used by the channel interfaces and guarded_page_allocator

package gpa_pkg;

  // default geometry of the managed region
  localparam int unsigned DEF_PAGES       = 1024;
  localparam int unsigned DEF_BLOCK_SLOTS = 512;
  localparam int unsigned DEF_PAGE_BYTES  = 4096;

  // field widths of the request and response words
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned ALIGN_W  = 13;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned STATUS_W = 2;

  // register port
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 64;
  localparam int unsigned REG_SEL_BIT = 3;
  localparam logic        REG_BASE    = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_OUT_RANGE = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_OWN,
    S_FQ,
    S_SC_START,
    S_SC_BLK,
    S_SC_CMP,
    S_SC_END,
    S_AL_RM,
    S_AL_T,
    S_AL_ON,
    S_AL_FIN,
    S_FL_START,
    S_FL_B,
    S_FL_BROW,
    S_FL_P,
    S_FL_BN,
    S_FL_N0,
    S_FL_N,
    S_FL_NN,
    S_FS_START,
    S_FS_CMP,
    S_FS_RM,
    S_FL_END,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/gpa_if.sv =====
// gpa_req_if / gpa_rsp_if: valid/ready channels carrying request and response words
// depends on gpa_pkg for field widths

interface gpa_req_if;
  import gpa_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SIZE_W-1:0]  request_bytes;
  logic [ALIGN_W-1:0] alignment;
  logic [ADDR_W-1:0]  address;

  modport source (output valid, kind, request_bytes, alignment, address, input ready);
  modport sink   (input valid, kind, request_bytes, alignment, address, output ready);
endinterface

interface gpa_rsp_if;
  import gpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   user_address;
  logic [SIZE_W-1:0]   usable_bytes;

  modport source (output valid, status, user_address, usable_bytes, input ready);
  modport sink   (input valid, status, user_address, usable_bytes, output ready);
endinterface

// ===== rtl/core/gpa_ram.sv =====
// gpa_ram: generic single write port, single read port ram with registered read
// no dependencies

module gpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/guarded_page_allocator.sv =====
// guarded_page_allocator: best-fit page allocator with guard pages and deferred coalescing
// depends on gpa_pkg, gpa_req_if / gpa_rsp_if and gpa_ram
// free and size query read the page owner, then the block row (an address outside the
//   region skips both); allocate scans the free list, with extra writes for a split, plus
//   on a failed fit a coalescing pass over the pending blocks and a second scan; one word
//   at a time, ready low while busy
// the single read port of the block table ram paces every step
// reset: a clearing pass writes the block and page tables; no word is taken meanwhile,
//   register writes are taken at any time

module guarded_page_allocator #(
  parameter int unsigned PAGES       = gpa_pkg::DEF_PAGES,
  parameter int unsigned BLOCK_SLOTS = gpa_pkg::DEF_BLOCK_SLOTS,
  parameter int unsigned PAGE_BYTES  = gpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gpa_req_if.sink                      req_i,
  gpa_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpa_pkg::PADDR_W-1:0]  paddr,
  input  logic [gpa_pkg::PDATA_W-1:0]  pwdata,
  output logic [gpa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import gpa_pkg::*;

  localparam int unsigned PGI_W  = $clog2(PAGES);
  localparam int unsigned PGN_W  = $clog2(PAGES + 1);
  localparam int unsigned SLI_W  = $clog2(BLOCK_SLOTS);
  localparam int unsigned SL_W   = $clog2(BLOCK_SLOTS + 1);
  localparam int unsigned CNT_W  = $clog2(BLOCK_SLOTS + 1);
  localparam int unsigned PB_LOG = $clog2(PAGE_BYTES);
  localparam int unsigned REQ_W  = SIZE_W + 1;
  localparam int unsigned SPAN_W = PGN_W + PB_LOG;
  localparam int unsigned UW     = (SPAN_W > SIZE_W + 1) ? SPAN_W : SIZE_W + 1;
  localparam int unsigned CLR_N  = (PAGES > BLOCK_SLOTS) ? PAGES : BLOCK_SLOTS;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam logic [SL_W-1:0] NIL_S = SL_W'(BLOCK_SLOTS);

  typedef struct packed {
    logic [PGI_W-1:0] start;
    logic [PGN_W-1:0] pages;
    logic             used;
    logic             pend;
    logic [SL_W-1:0]  prev;
    logic [SL_W-1:0]  next;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // ram ports
  logic             blk_we;
  logic [SLI_W-1:0] blk_waddr, blk_raddr;
  row_t             blk_wdata, blk_rdata;
  logic             fr_we;
  logic [SLI_W-1:0] fr_waddr, fr_raddr, fr_wdata, fr_rdata;
  logic             pd_we;
  logic [SLI_W-1:0] pd_waddr, pd_raddr, pd_wdata, pd_rdata;
  logic             own_we;
  logic [PGI_W-1:0] own_waddr, own_raddr;
  logic [SL_W-1:0]  own_wdata, own_rdata;

  // sequencer state
  state_e              state_q, state_d;
  logic [CLR_W-1:0]    clr_q, clr_d;
  logic [ADDR_W-1:0]   base_q;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [ALIGN_W-1:0]  align_q, align_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic                retry_q, retry_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    pidx_q, pidx_d;
  logic [CNT_W-1:0]    free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]    pend_cnt_q, pend_cnt_d;
  logic [SL_W-1:0]     spare_q, spare_d;
  logic                found_q, found_d;
  logic [SLI_W-1:0]    best_q, best_d;
  logic [PGN_W-1:0]    best_size_q, best_size_d;
  logic [SLI_W-1:0]    best_idx_q, best_idx_d;
  logic [SLI_W-1:0]    s_q, s_d;
  row_t                cur_q, cur_d;
  logic [SLI_W-1:0]    cur_slot_q, cur_slot_d;
  logic                removed_q, removed_d;
  logic [SL_W-1:0]     aux_q, aux_d;
  logic [SL_W-1:0]     t_q, t_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [ADDR_W-1:0]   ua_q, ua_d;
  logic [SIZE_W-1:0]   us_q, us_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]   rsp_uaddr_q, rsp_uaddr_d;
  logic [SIZE_W-1:0]   rsp_usable_q, rsp_usable_d;

  // derived request values
  logic [REQ_W-1:0]  req;
  logic              split;
  logic [SIZE_W-1:0] ideal, off32;
  logic [ADDR_W-1:0] uaddr;
  logic [ADDR_W-1:0] rel;
  logic              out_range;
  logic [PGI_W-1:0]  page_idx;
  logic [SPAN_W-1:0] span;
  logic [UW-1:0]     off_pg, diff;
  logic [SIZE_W-1:0] usable;
  logic [CNT_W-1:0]  idx_nxt, pidx_nxt;

  assign req   = REQ_W'(1) + ((REQ_W'(size_q) + REQ_W'(PAGE_BYTES - 1)) >> PB_LOG);
  assign split = REQ_W'(best_size_q) > req;
  assign ideal = (SIZE_W'(0) - size_q) & SIZE_W'(PAGE_BYTES - 1);
  assign off32 = ideal & ~(SIZE_W'(align_q) - SIZE_W'(1));
  assign uaddr = base_q + (ADDR_W'(cur_q.start) << PB_LOG) + ADDR_W'(off32);

  assign rel       = addr_q - base_q;
  assign out_range = (rel >> PB_LOG) >= ADDR_W'(PAGES);
  assign page_idx  = rel[PB_LOG +: PGI_W];
  assign span      = (blk_rdata.pages == '0) ? '0
                   : (SPAN_W'(blk_rdata.pages - 1'b1) << PB_LOG);
  assign off_pg    = UW'(rel[PB_LOG-1:0]);
  assign diff      = UW'(span) - off_pg;
  assign usable    = (UW'(span) > off_pg)
                   ? ((|diff[UW-1:SIZE_W]) ? '1 : diff[SIZE_W-1:0]) : '0;

  assign idx_nxt  = idx_q + 1'b1;
  assign pidx_nxt = pidx_q + 1'b1;

  // tables
  gpa_ram #(.WIDTH(ROW_W), .DEPTH(BLOCK_SLOTS)) u_blk_ram (
    .clk_i, .we_i(blk_we), .waddr_i(blk_waddr), .wdata_i(blk_wdata),
    .raddr_i(blk_raddr), .rdata_o(blk_rdata)
  );
  gpa_ram #(.WIDTH(SLI_W), .DEPTH(BLOCK_SLOTS)) u_free_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );
  gpa_ram #(.WIDTH(SLI_W), .DEPTH(BLOCK_SLOTS)) u_pend_ram (
    .clk_i, .we_i(pd_we), .waddr_i(pd_waddr), .wdata_i(pd_wdata),
    .raddr_i(pd_raddr), .rdata_o(pd_rdata)
  );
  gpa_ram #(.WIDTH(SL_W), .DEPTH(PAGES)) u_owner_ram (
    .clk_i, .we_i(own_we), .waddr_i(own_waddr), .wdata_i(own_wdata),
    .raddr_i(own_raddr), .rdata_o(own_rdata)
  );

  // register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (psel && penable && pwrite && paddr[REG_SEL_BIT] == REG_BASE) begin
      base_q <= pwdata[ADDR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_BASE) ? PDATA_W'(base_q) : '0;

  // channel ports
  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.user_address = rsp_uaddr_q;
  assign rsp_o.usable_bytes = rsp_usable_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      kind_q       <= '0;
      size_q       <= '0;
      align_q      <= '0;
      addr_q       <= '0;
      retry_q      <= 1'b0;
      idx_q        <= '0;
      pidx_q       <= '0;
      free_cnt_q   <= CNT_W'(1);
      pend_cnt_q   <= '0;
      spare_q      <= SL_W'(1);
      found_q      <= 1'b0;
      best_q       <= '0;
      best_size_q  <= '0;
      best_idx_q   <= '0;
      s_q          <= '0;
      cur_q        <= '0;
      cur_slot_q   <= '0;
      removed_q    <= 1'b0;
      aux_q        <= '0;
      t_q          <= '0;
      st_q         <= '0;
      ua_q         <= '0;
      us_q         <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_uaddr_q  <= '0;
      rsp_usable_q <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      kind_q       <= kind_d;
      size_q       <= size_d;
      align_q      <= align_d;
      addr_q       <= addr_d;
      retry_q      <= retry_d;
      idx_q        <= idx_d;
      pidx_q       <= pidx_d;
      free_cnt_q   <= free_cnt_d;
      pend_cnt_q   <= pend_cnt_d;
      spare_q      <= spare_d;
      found_q      <= found_d;
      best_q       <= best_d;
      best_size_q  <= best_size_d;
      best_idx_q   <= best_idx_d;
      s_q          <= s_d;
      cur_q        <= cur_d;
      cur_slot_q   <= cur_slot_d;
      removed_q    <= removed_d;
      aux_q        <= aux_d;
      t_q          <= t_d;
      st_q         <= st_d;
      ua_q         <= ua_d;
      us_q         <= us_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_status_q <= rsp_status_d;
      rsp_uaddr_q  <= rsp_uaddr_d;
      rsp_usable_q <= rsp_usable_d;
    end
  end

  // sequencer: next state, table accesses and result
  always_comb begin
    row_t row;
    logic merge;

    state_d      = state_q;
    clr_d        = clr_q;
    kind_d       = kind_q;
    size_d       = size_q;
    align_d      = align_q;
    addr_d       = addr_q;
    retry_d      = retry_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    free_cnt_d   = free_cnt_q;
    pend_cnt_d   = pend_cnt_q;
    spare_d      = spare_q;
    found_d      = found_q;
    best_d       = best_q;
    best_size_d  = best_size_q;
    best_idx_d   = best_idx_q;
    s_d          = s_q;
    cur_d        = cur_q;
    cur_slot_d   = cur_slot_q;
    removed_d    = removed_q;
    aux_d        = aux_q;
    t_d          = t_q;
    st_d         = st_q;
    ua_d         = ua_q;
    us_d         = us_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_uaddr_d  = rsp_uaddr_q;
    rsp_usable_d = rsp_usable_q;

    blk_we    = 1'b0;
    blk_waddr = '0;
    blk_wdata = '0;
    blk_raddr = '0;
    fr_we     = 1'b0;
    fr_waddr  = '0;
    fr_wdata  = '0;
    fr_raddr  = '0;
    pd_we     = 1'b0;
    pd_waddr  = '0;
    pd_wdata  = '0;
    pd_raddr  = '0;
    own_we    = 1'b0;
    own_waddr = '0;
    own_wdata = NIL_S;
    own_raddr = '0;
    row       = blk_rdata;
    merge     = 1'b0;

    case (state_q)
      // clearing pass over the block and page tables
      S_CLEAR: begin
        row       = '0;
        row.prev  = NIL_S;
        row.pages = (clr_q == '0) ? PGN_W'(PAGES) : '0;
        row.next  = (clr_q == '0) ? NIL_S : SL_W'(clr_q) + SL_W'(1);
        blk_we    = (32'(clr_q) < BLOCK_SLOTS);
        blk_waddr = clr_q[SLI_W-1:0];
        blk_wdata = row;
        own_we    = (32'(clr_q) < PAGES);
        own_waddr = clr_q[PGI_W-1:0];
        fr_we     = (clr_q == '0);
        if (32'(clr_q) == CLR_N - 1) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          kind_d  = req_i.kind;
          size_d  = req_i.request_bytes;
          align_d = req_i.alignment;
          addr_d  = req_i.address;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        st_d = ST_OK;
        ua_d = '0;
        us_d = '0;
        case (kind_q)
          KIND_ALLOC: begin
            retry_d = 1'b0;
            state_d = S_SC_START;
          end
          KIND_FREE, KIND_QUERY: begin
            if (out_range) begin
              st_d    = ST_OUT_RANGE;
              state_d = S_DONE;
            end else begin
              own_raddr = page_idx;
              state_d   = S_OWN;
            end
          end
          default: state_d = S_DONE;
        endcase
      end

      // free and query: owner lookup, then the block row
      S_OWN: begin
        if (own_rdata >= NIL_S) begin
          st_d    = ST_NOT_ALLOC;
          state_d = S_DONE;
        end else begin
          blk_raddr = own_rdata[SLI_W-1:0];
          s_d       = own_rdata[SLI_W-1:0];
          state_d   = S_FQ;
        end
      end

      S_FQ: begin
        if (kind_q == KIND_FREE) begin
          row.used  = 1'b0;
          row.pend  = 1'b1;
          blk_we    = 1'b1;
          blk_waddr = s_q;
          blk_wdata = row;
          own_we    = 1'b1;
          own_waddr = page_idx;
          if (32'(pend_cnt_q) < BLOCK_SLOTS) begin
            pd_we      = 1'b1;
            pd_waddr   = pend_cnt_q[SLI_W-1:0];
            pd_wdata   = s_q;
            pend_cnt_d = pend_cnt_q + 1'b1;
          end
        end else begin
          us_d = usable;
        end
        state_d = S_DONE;
      end

      // best-fit scan over the free list
      S_SC_START: begin
        found_d = 1'b0;
        idx_d   = '0;
        if (free_cnt_q == '0) begin
          state_d = S_SC_END;
        end else begin
          fr_raddr = '0;
          state_d  = S_SC_BLK;
        end
      end

      S_SC_BLK: begin
        blk_raddr = fr_rdata;
        s_d       = fr_rdata;
        state_d   = S_SC_CMP;
      end

      S_SC_CMP: begin
        if (REQ_W'(blk_rdata.pages) >= req && (!found_q || blk_rdata.pages < best_size_q)) begin
          found_d     = 1'b1;
          best_d      = s_q;
          best_size_d = blk_rdata.pages;
          best_idx_d  = idx_q[SLI_W-1:0];
        end
        if (idx_nxt < free_cnt_q) begin
          idx_d    = idx_nxt;
          fr_raddr = idx_nxt[SLI_W-1:0];
          state_d  = S_SC_BLK;
        end else begin
          state_d = S_SC_END;
        end
      end

      S_SC_END: begin
        if (!found_q || (split && spare_q == NIL_S)) begin
          if (retry_q) begin
            st_d    = ST_NO_MEM;
            ua_d    = '0;
            state_d = S_DONE;
          end else begin
            retry_d = 1'b1;
            state_d = S_FL_START;
          end
        end else begin
          fr_raddr  = SLI_W'(free_cnt_q - 1'b1);
          blk_raddr = best_q;
          state_d   = S_AL_RM;
        end
      end

      // take the chosen block: drop it from the free list
      S_AL_RM: begin
        fr_we      = 1'b1;
        fr_waddr   = best_idx_q;
        fr_wdata   = fr_rdata;
        free_cnt_d = free_cnt_q - 1'b1;
        cur_d      = blk_rdata;
        if (split) begin
          blk_raddr = spare_q[SLI_W-1:0];
          state_d   = S_AL_T;
        end else begin
          state_d = S_AL_FIN;
        end
      end

      // split off the tail into a spare slot
      S_AL_T: begin
        row.start  = cur_q.start + PGI_W'(req);
        row.pages  = best_size_q - PGN_W'(req);
        row.used   = 1'b0;
        row.pend   = 1'b0;
        row.prev   = SL_W'(best_q);
        row.next   = cur_q.next;
        blk_we     = 1'b1;
        blk_waddr  = spare_q[SLI_W-1:0];
        blk_wdata  = row;
        spare_d    = blk_rdata.next;
        t_d        = spare_q;
        aux_d      = cur_q.next;
        fr_we      = 1'b1;
        fr_waddr   = free_cnt_q[SLI_W-1:0];
        fr_wdata   = spare_q[SLI_W-1:0];
        free_cnt_d = free_cnt_q + 1'b1;
        cur_d.next  = spare_q;
        cur_d.pages = PGN_W'(req);
        if (cur_q.next < NIL_S) begin
          blk_raddr = cur_q.next[SLI_W-1:0];
          state_d   = S_AL_ON;
        end else begin
          state_d = S_AL_FIN;
        end
      end

      S_AL_ON: begin
        row.prev  = t_q;
        blk_we    = 1'b1;
        blk_waddr = aux_q[SLI_W-1:0];
        blk_wdata = row;
        state_d   = S_AL_FIN;
      end

      S_AL_FIN: begin
        row       = cur_q;
        row.used  = 1'b1;
        blk_we    = 1'b1;
        blk_waddr = best_q;
        blk_wdata = row;
        own_we    = 1'b1;
        own_waddr = cur_q.start;
        own_wdata = SL_W'(best_q);
        st_d      = ST_OK;
        ua_d      = uaddr;
        state_d   = S_DONE;
      end

      // coalescing pass over the pending list
      S_FL_START: begin
        pidx_d = '0;
        if (pend_cnt_q == '0) begin
          state_d = S_SC_START;
        end else begin
          pd_raddr = '0;
          state_d  = S_FL_B;
        end
      end

      S_FL_B: begin
        blk_raddr = pd_rdata;
        s_d       = pd_rdata;
        state_d   = S_FL_BROW;
      end

      S_FL_BROW: begin
        cur_d      = blk_rdata;
        cur_slot_d = s_q;
        removed_d  = 1'b0;
        if (blk_rdata.prev < NIL_S) begin
          blk_raddr = blk_rdata.prev[SLI_W-1:0];
          state_d   = S_FL_P;
        end else begin
          state_d = S_FL_N0;
        end
      end

      // merge into the left neighbor
      S_FL_P: begin
        merge = !blk_rdata.used && !blk_rdata.pend &&
                ({1'b0, blk_rdata.pages} + (PGN_W + 1)'(blk_rdata.start)) ==
                (PGN_W + 1)'(cur_q.start);
        if (merge) begin
          row       = cur_q;
          row.used  = 1'b0;
          row.pend  = 1'b0;
          row.prev  = NIL_S;
          row.next  = spare_q;
          blk_we    = 1'b1;
          blk_waddr = cur_slot_q;
          blk_wdata = row;
          spare_d   = SL_W'(cur_slot_q);
          cur_d       = blk_rdata;
          cur_d.next  = cur_q.next;
          cur_d.pages = blk_rdata.pages + cur_q.pages;
          cur_slot_d  = cur_q.prev[SLI_W-1:0];
          removed_d   = 1'b1;
          aux_d       = cur_q.next;
          if (cur_q.next < NIL_S) begin
            blk_raddr = cur_q.next[SLI_W-1:0];
            state_d   = S_FL_BN;
          end else begin
            state_d = S_FL_N0;
          end
        end else begin
          state_d = S_FL_N0;
        end
      end

      S_FL_BN: begin
        row.prev  = SL_W'(cur_slot_q);
        blk_we    = 1'b1;
        blk_waddr = aux_q[SLI_W-1:0];
        blk_wdata = row;
        state_d   = S_FL_N0;
      end

      S_FL_N0: begin
        aux_d = cur_q.next;
        if (cur_q.next < NIL_S) begin
          blk_raddr = cur_q.next[SLI_W-1:0];
          state_d   = S_FL_N;
        end else begin
          state_d = S_FL_END;
        end
      end

      // absorb the right neighbor
      S_FL_N: begin
        merge = !blk_rdata.used && !blk_rdata.pend &&
                (PGN_W + 1)'(blk_rdata.start) ==
                ({1'b0, cur_q.pages} + (PGN_W + 1)'(cur_q.start));
        if (merge) begin
          cur_d.next  = blk_rdata.next;
          cur_d.pages = cur_q.pages + blk_rdata.pages;
          row.used  = 1'b0;
          row.pend  = 1'b0;
          row.prev  = NIL_S;
          row.next  = spare_q;
          blk_we    = 1'b1;
          blk_waddr = aux_q[SLI_W-1:0];
          blk_wdata = row;
          spare_d   = aux_q;
          t_d       = blk_rdata.next;
          if (blk_rdata.next < NIL_S) begin
            blk_raddr = blk_rdata.next[SLI_W-1:0];
            state_d   = S_FL_NN;
          end else begin
            state_d = S_FS_START;
          end
        end else begin
          state_d = S_FL_END;
        end
      end

      S_FL_NN: begin
        row.prev  = SL_W'(cur_slot_q);
        blk_we    = 1'b1;
        blk_waddr = t_q[SLI_W-1:0];
        blk_wdata = row;
        state_d   = S_FS_START;
      end

      // find the absorbed neighbor in the free list and drop it
      S_FS_START: begin
        idx_d = '0;
        if (free_cnt_q == '0) begin
          state_d = S_FL_END;
        end else begin
          fr_raddr = '0;
          state_d  = S_FS_CMP;
        end
      end

      S_FS_CMP: begin
        if (fr_rdata == aux_q[SLI_W-1:0]) begin
          fr_raddr = SLI_W'(free_cnt_q - 1'b1);
          state_d  = S_FS_RM;
        end else if (idx_nxt < free_cnt_q) begin
          idx_d    = idx_nxt;
          fr_raddr = idx_nxt[SLI_W-1:0];
        end else begin
          state_d = S_FL_END;
        end
      end

      S_FS_RM: begin
        fr_we      = 1'b1;
        fr_waddr   = idx_q[SLI_W-1:0];
        fr_wdata   = fr_rdata;
        free_cnt_d = free_cnt_q - 1'b1;
        state_d    = S_FL_END;
      end

      // write back the surviving block, next pending entry
      S_FL_END: begin
        row = cur_q;
        if (!removed_q) begin
          row.pend = 1'b0;
          if (32'(free_cnt_q) < BLOCK_SLOTS) begin
            fr_we      = 1'b1;
            fr_waddr   = free_cnt_q[SLI_W-1:0];
            fr_wdata   = cur_slot_q;
            free_cnt_d = free_cnt_q + 1'b1;
          end
        end
        blk_we    = 1'b1;
        blk_waddr = cur_slot_q;
        blk_wdata = row;
        if (pidx_nxt < pend_cnt_q) begin
          pidx_d   = pidx_nxt;
          pd_raddr = pidx_nxt[SLI_W-1:0];
          state_d  = S_FL_B;
        end else begin
          pend_cnt_d = '0;
          state_d    = S_SC_START;
        end
      end

      // hand the word to the output register
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = st_q;
          rsp_uaddr_d  = ua_q;
          rsp_usable_d = us_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // checks
  a_fit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AL_RM |-> found_q)
    else $error("block taken without a fitting candidate");

  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_cnt_q) <= BLOCK_SLOTS && 32'(pend_cnt_q) <= BLOCK_SLOTS)
    else $error("free or pending list exceeds slot count");

  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
    else $error("response raised outside completion");

  a_spare_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_q <= NIL_S)
    else $error("spare head out of range");

endmodule

// ===== verif/tb_guarded_page_allocator.sv =====
// tb_guarded_page_allocator: self-checking bench for the guarded page allocator
// depends on gpa_pkg, gpa_req_if / gpa_rsp_if and rtl/core/guarded_page_allocator
// an in-bench allocator model predicts every response word; a monitor compares in order

module tb_guarded_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import gpa_pkg::*;

  localparam int unsigned NPAGES = DEF_PAGES;
  localparam int unsigned NSLOTS = DEF_BLOCK_SLOTS;
  localparam int unsigned PBYTES = DEF_PAGE_BYTES;
  localparam int unsigned NIL    = NSLOTS;
  localparam logic [47:0] TOP_BASE = 48'hFFFF_FFFF_F000;

  typedef struct packed {
    status_e     status;
    logic [47:0] user_address;
    logic [31:0] usable_bytes;
  } answer_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  gpa_req_if req_ch ();
  gpa_rsp_if rsp_ch ();

  guarded_page_allocator uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch.sink),
    .rsp_o   (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator model state
  logic [47:0] heap_base;
  int unsigned blk_start [NSLOTS];
  int unsigned blk_pages [NSLOTS];
  bit          blk_used  [NSLOTS];
  bit          blk_pend  [NSLOTS];
  int unsigned blk_prev  [NSLOTS];
  int unsigned blk_next  [NSLOTS];
  int unsigned spare_slot;
  int unsigned avail_list [NSLOTS];
  int unsigned n_free;
  int unsigned pend_list [NSLOTS];
  int unsigned n_pend;
  int unsigned page_owner_of [NPAGES];

  answer_t     answers_due[$];
  logic [47:0] live_addrs[$];
  int          errors;
  bit          idle_on;
  int          hold_len;

  function automatic void heap_reset();
    for (int i = 0; i < NSLOTS; i++) begin
      blk_start[i] = 0;
      blk_pages[i] = 0;
      blk_used[i]  = 0;
      blk_pend[i]  = 0;
      blk_prev[i]  = NIL;
      blk_next[i]  = i + 1;
      avail_list[i] = 0;
    end
    blk_pages[0] = NPAGES;
    blk_next[0]  = NIL;
    spare_slot   = 1;
    n_free       = 1;
    n_pend       = 0;
    heap_base    = '0;
    for (int i = 0; i < NPAGES; i++) page_owner_of[i] = NIL;
  endfunction

  function automatic void slot_release(int unsigned s);
    blk_used[s] = 0;
    blk_pend[s] = 0;
    blk_prev[s] = NIL;
    blk_next[s] = spare_slot;
    spare_slot  = s;
  endfunction

  function automatic void avail_push(int unsigned s);
    if (n_free < NSLOTS) begin
      avail_list[n_free] = s;
      n_free++;
    end
  endfunction

  function automatic void avail_drop(int unsigned i);
    if (i < n_free) begin
      avail_list[i] = avail_list[n_free-1];
      n_free--;
    end
  endfunction

  // best fit; returns NIL and leaves state alone on failure
  function automatic int unsigned best_fit_take(longint unsigned need);
    int unsigned best, best_size, best_idx, s, t, old_next;
    best = NIL;
    best_size = 32'hFFFF_FFFF;
    best_idx = 0;
    for (int unsigned i = 0; i < n_free; i++) begin
      s = avail_list[i];
      if (s >= NSLOTS) continue;
      if (longint'(blk_pages[s]) >= need && blk_pages[s] < best_size) begin
        best = s;
        best_size = blk_pages[s];
        best_idx = i;
      end
    end
    if (best == NIL) return NIL;
    if (longint'(best_size) > need && spare_slot == NIL) return NIL;
    avail_drop(best_idx);
    if (longint'(best_size) > need) begin
      t = spare_slot;
      old_next = blk_next[best];
      spare_slot = blk_next[t];
      blk_used[t]  = 0;
      blk_pend[t]  = 0;
      blk_start[t] = blk_start[best] + int'(need);
      blk_pages[t] = best_size - int'(need);
      blk_next[t]  = old_next;
      blk_prev[t]  = best;
      if (old_next < NSLOTS) blk_prev[old_next] = t;
      blk_next[best] = t;
      avail_push(t);
      blk_pages[best] = int'(need);
    end
    blk_used[best] = 1;
    if (blk_start[best] < NPAGES) page_owner_of[blk_start[best]] = best;
    return best;
  endfunction

  // merge pending blocks with free neighbours
  function automatic void coalesce_pending();
    int unsigned b, p, n, bn, nn;
    bit removed;
    for (int unsigned i = 0; i < n_pend; i++) begin
      b = pend_list[i];
      removed = 0;
      if (b >= NSLOTS) continue;
      p = blk_prev[b];
      if (p < NSLOTS && !blk_used[p] && !blk_pend[p] &&
          blk_start[p] + blk_pages[p] == blk_start[b]) begin
        bn = blk_next[b];
        blk_next[p] = bn;
        if (bn < NSLOTS) blk_prev[bn] = p;
        blk_pages[p] += blk_pages[b];
        slot_release(b);
        b = p;
        removed = 1;
      end
      n = blk_next[b];
      if (n < NSLOTS && !blk_used[n] && !blk_pend[n] &&
          blk_start[n] == blk_start[b] + blk_pages[b]) begin
        nn = blk_next[n];
        blk_next[b] = nn;
        if (nn < NSLOTS) blk_prev[nn] = b;
        blk_pages[b] += blk_pages[n];
        for (int unsigned k = 0; k < n_free; k++) begin
          if (avail_list[k] == n) begin
            avail_drop(k);
            break;
          end
        end
        slot_release(n);
      end
      if (!removed) begin
        blk_pend[b] = 0;
        avail_push(b);
      end
    end
    n_pend = 0;
  endfunction

  // expected response to one accepted request word
  function automatic answer_t heap_answer(logic [1:0] kind, logic [31:0] size,
                                          logic [12:0] align, logic [47:0] addr);
    answer_t a;
    longint unsigned need, span, off, usable;
    int unsigned s, ideal, uoff, b;
    logic [47:0] rel;
    logic [31:0] amask;
    a = '{status: ST_OK, user_address: '0, usable_bytes: '0};
    if (kind == KIND_ALLOC) begin
      need = 1 + (longint'(size) + PBYTES - 1) / PBYTES;
      s = best_fit_take(need);
      if (s == NIL) begin
        coalesce_pending();
        s = best_fit_take(need);
      end
      if (s == NIL) begin
        a.status = ST_NO_MEM;
      end else begin
        ideal = (PBYTES - size % PBYTES) % PBYTES;
        amask = 32'(align) - 32'd1;
        uoff = ideal & ~amask;
        a.user_address = heap_base + 48'(blk_start[s]) * PBYTES + 48'(uoff);
      end
    end else if (kind == KIND_FREE || kind == KIND_QUERY) begin
      rel = addr - heap_base;
      if (rel / PBYTES >= NPAGES) begin
        a.status = ST_OUT_RANGE;
      end else begin
        b = page_owner_of[rel / PBYTES];
        if (b >= NSLOTS) begin
          a.status = ST_NOT_ALLOC;
        end else if (kind == KIND_FREE) begin
          blk_used[b] = 0;
          blk_pend[b] = 1;
          page_owner_of[rel / PBYTES] = NIL;
          if (n_pend < NSLOTS) begin
            pend_list[n_pend] = b;
            n_pend++;
          end
        end else begin
          span = blk_pages[b] > 0 ? longint'(blk_pages[b] - 1) * PBYTES : 0;
          off = rel % PBYTES;
          usable = span > off ? span - off : 0;
          if (usable > 64'hFFFF_FFFF) usable = 64'hFFFF_FFFF;
          a.usable_bytes = usable[31:0];
        end
      end
    end
    return a;
  endfunction

  // monitor: check responses, then predict accepted requests
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response word status=%0d", rsp_ch.status);
        end else begin
          want = answers_due.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.user_address !== want.user_address ||
              rsp_ch.usable_bytes !== want.usable_bytes) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected st=%0d ua=%h ub=%h got st=%0d ua=%h ub=%h",
                       want.status, want.user_address, want.usable_bytes,
                       rsp_ch.status, rsp_ch.user_address, rsp_ch.usable_bytes);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        want = heap_answer(req_ch.kind, req_ch.request_bytes, req_ch.alignment,
                           req_ch.address);
        answers_due.push_back(want);
        if (req_ch.kind == KIND_ALLOC && want.status == ST_OK)
          live_addrs.push_back(want.user_address);
        if (req_ch.kind == KIND_FREE && want.status == ST_OK)
          foreach (live_addrs[i])
            if (live_addrs[i] == req_ch.address) begin
              live_addrs.delete(i);
              break;
            end
      end
    end
  end

  // response side: random stalls and a requested long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // send one request word, with an optional idle burst first
  task automatic send_word(logic [1:0] kind, logic [31:0] size, logic [12:0] align,
                           logic [47:0] addr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.request_bytes <= size;
    req_ch.alignment     <= align;
    req_ch.address       <= addr;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // wait for all answers, then settle before touching registers
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_base(logic [47:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {PADDR_W{1'b0}};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    heap_base = value;
  endtask

  function automatic logic [47:0] pick_live();
    if (live_addrs.size() == 0) return heap_base;
    return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
  endfunction

  function automatic logic [12:0] pick_align();
    if ($urandom_range(0, 9) == 0) return 13'($urandom);
    return 13'(1 << $urandom_range(0, 12));
  endfunction

  // one random request word, mostly well formed
  task automatic send_random();
    int unsigned r;
    logic [31:0] size;
    logic [47:0] a;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      case ($urandom_range(0, 19))
        0:       size = $urandom;
        1:       size = $urandom_range(0, 32'h0040_0000);
        default: size = $urandom_range(0, 20000);
      endcase
      send_word(KIND_ALLOC, size, pick_align(), 48'({$urandom, $urandom}));
    end else if (r < 95) begin
      case ($urandom_range(0, 9))
        0:       a = 48'({$urandom, $urandom});
        1:       a = heap_base + 48'($urandom_range(0, NPAGES * PBYTES - 1));
        2:       a = pick_live() + 48'($urandom_range(1, 3 * PBYTES));
        default: a = pick_live();
      endcase
      send_word(r < 80 ? KIND_FREE : KIND_QUERY, $urandom, 13'($urandom), a);
    end else begin
      send_word(KIND_NOP, $urandom, 13'($urandom), 48'({$urandom, $urandom}));
    end
  endtask

  task automatic test_directed();
    logic [47:0] a;
    send_word(KIND_ALLOC, 32'd0, 13'd1, '0);
    send_word(KIND_ALLOC, 32'd1, 13'd4096, '0);
    send_word(KIND_ALLOC, 32'd4096, 13'd0, '0);
    send_word(KIND_ALLOC, 32'd4097, 13'h1FFF, 48'hFFFF_FFFF_FFFF);
    send_word(KIND_ALLOC, 32'd100, 13'd3, '0);
    send_word(KIND_ALLOC, 32'hFFFF_FFFF, 13'd16, '0);
    send_word(KIND_ALLOC, 32'd1023 * PBYTES, 13'd8, '0);
    drain();
    a = pick_live();
    send_word(KIND_QUERY, '0, '0, a);
    send_word(KIND_QUERY, '0, '0, a + 48'd4095);
    send_word(KIND_QUERY, '0, '0, a + 48'(PBYTES));
    send_word(KIND_FREE, 32'hFFFF_FFFF, 13'h1FFF, a);
    send_word(KIND_FREE, '0, '0, a);
    send_word(KIND_QUERY, '0, '0, a);
    send_word(KIND_FREE, '0, '0, heap_base - 48'd1);
    send_word(KIND_QUERY, '0, '0, heap_base + 48'(NPAGES * PBYTES));
    send_word(KIND_QUERY, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_word(KIND_NOP, 32'hFFFF_FFFF, 13'h1FFF, 48'hFFFF_FFFF_FFFF);
    send_word(KIND_FREE, '0, '0, pick_live());
    // fill the region so the retry after coalescing is exercised
    send_word(KIND_ALLOC, 32'd900 * PBYTES, 13'd1, '0);
    send_word(KIND_ALLOC, 32'd20 * PBYTES, 13'd1, '0);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_random();
    drain();
  endtask

  // response side holds off while requests keep coming
  task automatic test_backpressure();
    hold_len = 400;
    repeat (20) send_random();
    drain();
  endtask

  task automatic test_base_register();
    write_base(TOP_BASE);
    repeat (8) send_random();
    send_word(KIND_QUERY, '0, '0, 48'h0000_0000_0FFF);
    drain();
    write_base(48'({$urandom, $urandom}) & ~48'(PBYTES - 1));
    repeat (8) send_random();
    drain();
    write_base('0);
    drain();
  endtask

  // timeout
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    errors   = 0;
    idle_on  = 1'b1;
    hold_len = 0;
    heap_reset();
    rst_ni          = 1'b0;
    clk_i           = 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= KIND_NOP;
    req_ch.request_bytes <= '0;
    req_ch.alignment     <= '0;
    req_ch.address       <= '0;
    rsp_ch.ready    <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_base('0);
    test_directed();
    test_backpressure();
    test_base_register();
    test_random(450);
    idle_on = 1'b0;
    test_random(80);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
